### src/ssdsp_pkg.sv
// ----------------------------------------------------------------------------
// ssdsp_pkg
// Shared constants and types of the step-sequenced drum sample player.
// ----------------------------------------------------------------------------
`default_nettype none
package ssdsp_pkg;
  localparam int unsigned NumSteps   = 16;
  localparam int unsigned NumVoices  = 6;
  localparam int unsigned VoiceWords = 16384;
  localparam int unsigned StepW      = $clog2(NumSteps);
  localparam int unsigned VoiceW     = $clog2(NumVoices);
  localparam int unsigned WordAw     = $clog2(VoiceWords);
  localparam int unsigned StoreDepth = NumVoices * VoiceWords;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);

  typedef enum logic [2:0] {
    OpTick    = 3'd0,
    OpWrite   = 3'd1,
    OpPattern = 3'd2,
    OpLength  = 3'd3,
    OpStop    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StAcc,
    StOut
  } state_e;

  localparam logic [0:0] CfgStepLen  = 1'b0;
  localparam logic [0:0] CfgMonoMask = 1'b1;
endpackage
`default_nettype wire

### src/ssdsp_ram.sv
// ----------------------------------------------------------------------------
// ssdsp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ssdsp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] addr_i,
  input  wire [Width-1:0]         wdata_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

### src/step_sequenced_drum_sample_player.sv
// ----------------------------------------------------------------------------
// step_sequenced_drum_sample_player
// Drum pattern sequencer mixing six sample voices out of one sample memory.
// ----------------------------------------------------------------------------
// Non-tick operations are applied as they are accepted. A tick walks the voices
// one sample memory read a cycle through the single sample memory port, then
// accumulates and outputs; no new item is taken until the result is loaded
// into the output register. A result waiting in the output register holds
// only the end of the next tick. Reset clears sequencer, pattern and voice
// state at once; the sample memory is not cleared.
`default_nettype none
module step_sequenced_drum_sample_player (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // op[2:0], voice[5:3], address[20:6], left_word[36:21], right_word[52:37],
  // step_mask[58:53], zero fill
  input  wire  [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // left_out[15:0], right_out[31:16], step_index[35:32], step_start[36],
  // fired_mask[42:37], zero fill
  output logic [47:0] m_axis_tdata,
  input  wire         cfg_we_i,
  input  wire  [0:0]  cfg_index_i,
  input  wire  [19:0] cfg_wdata_i
);
  import ssdsp_pkg::*;

  logic [19:0] step_len_q;
  logic [5:0]  mono_q;
  logic [19:0] sub_q;
  logic [StepW-1:0] cur_q;
  logic [5:0]  pat_q [NumSteps];
  logic [14:0] pos_q [NumVoices];
  logic [14:0] len_q [NumVoices];
  logic [NumVoices-1:0] act_q;
  state_e st_q, st_d;
  logic [VoiceW-1:0] vi_q;      // voice being read
  logic [VoiceW-1:0] va_q;      // voice whose data arrives
  logic              va_ok_q;
  logic signed [18:0] lsum_q, rsum_q;
  logic        bnd_q;
  logic [5:0]  fired_q;
  logic [StepW-1:0] shown_q;
  logic        ov_q;
  logic [47:0] od_q;

  wire [2:0]  in_op   = s_axis_tdata[2:0];
  wire [2:0]  in_v    = s_axis_tdata[5:3];
  wire [14:0] in_addr = s_axis_tdata[20:6];
  wire [31:0] in_word = s_axis_tdata[52:21];
  wire [5:0]  in_mask = s_axis_tdata[58:53];

  assign s_axis_tready = (st_q == StIdle);
  wire acc = s_axis_tvalid && s_axis_tready;
  // hold the finished mix until the output register is free
  wire out_load = (st_q == StOut) && (!ov_q || m_axis_tready);

  // sample memory: write on op 1, else read for the voice being walked
  logic              ram_we;
  logic [StoreAw-1:0] ram_a;
  logic [31:0]       ram_q;
  always_comb begin
    ram_we = acc && (in_op == OpWrite) && (in_v < NumVoices) &&
             (in_addr < VoiceWords);
    if (st_q == StIdle)
      ram_a = StoreAw'(in_v * VoiceWords + in_addr[WordAw-1:0]);
    else
      ram_a = StoreAw'(vi_q * VoiceWords + pos_q[vi_q][WordAw-1:0]);
  end

  ssdsp_ram #(.Width(32), .Depth(StoreDepth)) u_store (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_a),
    .wdata_i(in_word), .rdata_o(ram_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else         st_q <= st_d;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (acc && in_op == OpTick) st_d = StRead;
      StRead: if (vi_q == VoiceW'(NumVoices - 1)) st_d = StAcc;
      StAcc:  st_d = StOut;
      StOut:  if (!ov_q || m_axis_tready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  wire [5:0] fire_now = pat_q[cur_q] & 6'((1 << NumVoices) - 1);
  wire       active_cur = act_q[vi_q] && (pos_q[vi_q] < len_q[vi_q]);
  wire signed [15:0] wl = ram_q[15:0];
  wire signed [15:0] wr = mono_q[va_q] ? ram_q[15:0] : ram_q[31:16];
  wire [19:0] sub_inc = sub_q + 20'd1;
  wire [19:0] eff_len = (step_len_q == 20'd0) ? 20'd1 : step_len_q;

  function automatic logic [15:0] sat(input logic signed [18:0] x);
    if (x > 19'sd32767)       sat = 16'h7fff;
    else if (x < -19'sd32768) sat = 16'h8000;
    else                      sat = x[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_len_q <= 20'd6000;
      mono_q     <= '0;
      sub_q      <= '0;
      cur_q      <= '0;
      act_q      <= '0;
      ov_q       <= 1'b0;
      va_ok_q    <= 1'b0;
      vi_q       <= '0;
      for (int i = 0; i < NumSteps; i++) pat_q[i] <= '0;
      for (int i = 0; i < NumVoices; i++) begin
        pos_q[i] <= '0;
        len_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgStepLen) step_len_q <= cfg_wdata_i;
        else                           mono_q <= cfg_wdata_i[5:0];
      end
      va_ok_q <= 1'b0;
      if (acc) begin
        case (in_op)
          OpPattern: if (in_addr < NumSteps) pat_q[in_addr[StepW-1:0]] <= in_mask;
          OpLength:  if (in_v < NumVoices)
                       len_q[in_v[VoiceW-1:0]] <= (in_addr > VoiceWords) ?
                         15'(VoiceWords) : in_addr;
          OpStop:    act_q <= '0;
          OpTick: begin
            // retrigger fired voices at a step boundary, advance the step counters and start a new mix
            shown_q <= cur_q;
            bnd_q   <= (sub_q == 20'd0);
            fired_q <= (sub_q == 20'd0) ? fire_now : 6'd0;
            if (sub_q == 20'd0)
              for (int i = 0; i < NumVoices; i++)
                if (fire_now[i]) begin
                  act_q[i] <= 1'b1;
                  pos_q[i] <= '0;
                end
            if (sub_inc >= eff_len) begin
              sub_q <= '0;
              cur_q <= StepW'((cur_q + 1) % NumSteps);
            end else begin
              sub_q <= sub_inc;
            end
            vi_q   <= '0;
            lsum_q <= '0;
            rsum_q <= '0;
          end
          default: ;
        endcase
      end
      if (st_q == StRead) begin
        va_q    <= vi_q;
        va_ok_q <= active_cur;
        if (active_cur) begin
          pos_q[vi_q] <= pos_q[vi_q] + 15'd1;
          if (pos_q[vi_q] + 15'd1 >= len_q[vi_q]) act_q[vi_q] <= 1'b0;
        end else begin
          act_q[vi_q] <= 1'b0;
        end
        if (vi_q != VoiceW'(NumVoices - 1)) vi_q <= vi_q + 1'b1;
      end
      if (va_ok_q) begin
        lsum_q <= lsum_q + 19'(wl);
        rsum_q <= rsum_q + 19'(wr);
      end
      if (out_load) begin
        ov_q <= 1'b1;
        od_q <= {5'd0, fired_q, bnd_q, 4'(shown_q), sat(rsum_q), sat(lsum_q)};
      end else if (m_axis_tvalid && m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  ack_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !s_axis_tready) else $error("ready while busy");
  out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_axis_tready) |=> (ov_q && $stable(od_q)))
    else $error("result overwritten");
  fired_bnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !od_q[36]) |-> (od_q[42:37] == 6'd0)) else $error("fired off boundary");
endmodule
`default_nettype wire
